// ----- rtl/tsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the telnet stream parser.
package tsp_pkg;

  localparam logic [7:0] IAC_BYTE  = 8'hFF;
  localparam logic [7:0] SB_BYTE   = 8'd250;
  localparam logic [7:0] SE_BYTE   = 8'd240;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_PAY  = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_IAC     = 7'b0000010,
    PH_CMD_OPT = 7'b0000100,
    PH_SB_OPT  = 7'b0001000,
    PH_SB_DIR  = 7'b0010000,
    PH_SB_PAY  = 7'b0100000,
    PH_SB_IAC  = 7'b1000000
  } phase_t;

  // One queued operation; dual means a payload 0xFF beat goes out before value.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] option;
    logic       dir;
    logic       dual;
  } tsp_entry_t;

endpackage

// ----- rtl/tsp_if.sv -----
`timescale 1ns / 1ps
// Input byte channel and result channel interfaces.
interface tsp_in_if import tsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tsp_out_if import tsp_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] value_byte;
  logic [7:0] option_code;
  logic       direction_flag;
  logic       last;

  modport source (output valid, output kind, output value_byte, output option_code,
                  output direction_flag, output last, input ready);
  modport sink   (input valid, input kind, input value_byte, input option_code,
                  input direction_flag, input last, output ready);
endinterface

// ----- rtl/tsp_front.sv -----
`timescale 1ns / 1ps
// Front end: telnet phase tracking and classification of each received byte.
module tsp_front import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       push_valid,
  output tsp_entry_t push_entry
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_cmd_r, held_cmd_nxt;
  logic [7:0] held_opt_r, held_opt_nxt;
  logic       held_dir_r, held_dir_nxt;
  logic       accept;
  logic       emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push_valid = accept && emit;

  always_comb begin
    phase_nxt    = phase_r;
    held_cmd_nxt = held_cmd_r;
    held_opt_nxt = held_opt_r;
    held_dir_nxt = held_dir_r;
    emit         = 1'b0;
    push_entry   = '{kind: KIND_PAY, value: rx_byte, option: held_opt_r,
                     dir: held_dir_r, dual: 1'b0};
    unique case (phase_r)
      PH_IAC: begin
        if (rx_byte == SB_BYTE) begin
          phase_nxt = PH_SB_OPT;
        end else begin
          held_cmd_nxt = rx_byte;
          phase_nxt    = PH_CMD_OPT;
        end
      end
      PH_CMD_OPT: begin
        phase_nxt  = PH_IDLE;
        emit       = 1'b1;
        push_entry = '{kind: KIND_CMD, value: held_cmd_r, option: rx_byte,
                       dir: 1'b0, dual: 1'b0};
      end
      PH_SB_OPT: begin
        held_opt_nxt = rx_byte;
        phase_nxt    = PH_SB_DIR;
      end
      PH_SB_DIR: begin
        held_dir_nxt = (rx_byte != 8'd0);
        phase_nxt    = PH_SB_PAY;
      end
      PH_SB_PAY: begin
        if (rx_byte == IAC_BYTE) begin
          phase_nxt = PH_SB_IAC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SB_IAC: begin
        emit = 1'b1;
        if (rx_byte == SE_BYTE) begin
          phase_nxt        = PH_IDLE;
          push_entry.kind  = KIND_END;
          push_entry.value = 8'd0;
        end else if (rx_byte == IAC_BYTE) begin
          // escaped IAC stays pending; previous one goes out as payload
          push_entry.value = IAC_BYTE;
        end else begin
          phase_nxt       = PH_SB_PAY;
          push_entry.dual = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (rx_byte == IAC_BYTE) begin
          phase_nxt = PH_IAC;
        end else if (!rx_byte[7]) begin
          emit       = 1'b1;
          push_entry = '{kind: KIND_DATA, value: rx_byte, option: 8'd0,
                         dir: 1'b0, dual: 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      held_cmd_r <= 8'd0;
      held_opt_r <= 8'd0;
      held_dir_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      held_cmd_r <= held_cmd_nxt;
      held_opt_r <= held_opt_nxt;
      held_dir_r <= held_dir_nxt;
    end
  end

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_entry.kind == KIND_END) |=> (phase_r == PH_IDLE))
    else $error("subnegotiation end did not return to idle");

  a_dual_leaves_pay: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_entry.dual) |-> (phase_r == PH_SB_IAC && push_entry.kind == KIND_PAY))
    else $error("split payload beat outside pending IAC");

endmodule

// ----- rtl/tsp_queue.sv -----
`timescale 1ns / 1ps
// Short queue of classified operations between front and back ends.
module tsp_queue import tsp_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsp_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output tsp_entry_t head,
  output logic       empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tsp_entry_t      slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

// ----- rtl/tsp_back.sv -----
`timescale 1ns / 1ps
// Back end: expands queued operations into result beats through an output register.
module tsp_back import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tsp_entry_t head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_option,
  output logic       out_dir,
  output logic       out_last
);

  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] value_r;
  logic [7:0] option_r;
  logic       dir_r;
  logic       last_r;
  logic       sec_r;       // second beat of a split payload still owed
  logic [7:0] sec_val_r;
  logic       load;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && !sec_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= sec_r || !q_empty;
      if (sec_r) begin
        sec_r <= 1'b0;
      end else if (!q_empty) begin
        sec_r <= head.dual;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && sec_r) begin
      value_r <= sec_val_r;
      last_r  <= 1'b1;
    end else if (pop) begin
      kind_r    <= head.kind;
      value_r   <= head.dual ? IAC_BYTE : head.value;
      option_r  <= head.option;
      dir_r     <= head.dir;
      last_r    <= !head.dual;
      sec_val_r <= head.value;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_value  = value_r;
  assign out_option = option_r;
  assign out_dir    = dir_r;
  assign out_last   = last_r;

  a_sec_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r |-> (out_valid_r && !last_r && kind_r == KIND_PAY && value_r == IAC_BYTE))
    else $error("second payload beat owed without matching first beat");

  a_sec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r && out_ready) |=> (out_valid_r && last_r && !sec_r && kind_r == KIND_PAY))
    else $error("second payload beat not issued");

endmodule

// ----- rtl/telnet_stream_parser.sv -----
`timescale 1ns / 1ps
// Top level of the telnet receive stream parser.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | rx_byte
//  out_ch   | out | kind, value_byte, option_code, direction_flag, last
//
// One byte accepted per cycle while the operation queue has room.
// A result beat passes through the operation queue and the output register; an
// IAC-then-other-byte in a payload yields two beats and blocks queue pops until the second.
// Reset (synchronous) returns to the idle data phase and empties queue and output.
// With out_ch.ready low, FIFO_DEPTH operations plus one output beat are held
// before in_ch.ready falls.
module telnet_stream_parser import tsp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tsp_in_if.sink    in_ch,
  tsp_out_if.source out_ch
);

  logic       q_full, q_empty, push, pop;
  tsp_entry_t push_entry, head;

  tsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .rx_byte    (in_ch.rx_byte),
    .q_full     (q_full),
    .push_valid (push),
    .push_entry (push_entry)
  );

  tsp_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  tsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.kind),
    .out_value  (out_ch.value_byte),
    .out_option (out_ch.option_code),
    .out_dir    (out_ch.direction_flag),
    .out_last   (out_ch.last)
  );

endmodule

// ----- tb/sv/tsp_checker.sv -----
`timescale 1ns / 1ps
// Checker for the telnet stream parser: predicts result beats per input byte and compares them.
module tsp_checker import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  kind_t      out_kind,
  input  logic [7:0] out_value,
  input  logic [7:0] out_option,
  input  logic       out_dir,
  input  logic       out_last,
  output int         fail_count,
  output int         pending_count,
  output int         beats_checked
);

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] option;
    logic       dir;
    logic       last;
  } beat_t;

  beat_t      expected_beats[$];
  phase_t     phase;
  logic [7:0] cmd_hold;
  logic [7:0] opt_hold;
  logic       dir_hold;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    beats_checked = 0;
    phase         = PH_IDLE;
    cmd_hold      = 8'h00;
    opt_hold      = 8'h00;
    dir_hold      = 1'b0;
  end

  function automatic void push_beat(kind_t k, logic [7:0] v, logic [7:0] o, logic d,
                                    logic l);
    beat_t bt;
    bt.kind   = k;
    bt.value  = v;
    bt.option = o;
    bt.dir    = d;
    bt.last   = l;
    expected_beats.push_back(bt);
  endfunction

  // Advance the parse phase by one byte and queue the beats it causes.
  function automatic void parse_byte(logic [7:0] b);
    case (phase)
      PH_IAC: begin
        if (b == SB_BYTE) begin
          phase = PH_SB_OPT;
        end else begin
          cmd_hold = b;
          phase    = PH_CMD_OPT;
        end
      end
      PH_CMD_OPT: begin
        phase = PH_IDLE;
        push_beat(KIND_CMD, cmd_hold, b, 1'b0, 1'b1);
      end
      PH_SB_OPT: begin
        opt_hold = b;
        phase    = PH_SB_DIR;
      end
      PH_SB_DIR: begin
        dir_hold = (b != 8'h00);
        phase    = PH_SB_PAY;
      end
      PH_SB_PAY: begin
        if (b == IAC_BYTE) phase = PH_SB_IAC;
        else push_beat(KIND_PAY, b, opt_hold, dir_hold, 1'b1);
      end
      PH_SB_IAC: begin
        if (b == SE_BYTE) begin
          phase = PH_IDLE;
          push_beat(KIND_END, 8'h00, opt_hold, dir_hold, 1'b1);
        end else if (b == IAC_BYTE) begin
          // escaped 0xFF; the second IAC stays pending
          push_beat(KIND_PAY, IAC_BYTE, opt_hold, dir_hold, 1'b1);
        end else begin
          phase = PH_SB_PAY;
          push_beat(KIND_PAY, IAC_BYTE, opt_hold, dir_hold, 1'b0);
          push_beat(KIND_PAY, b, opt_hold, dir_hold, 1'b1);
        end
      end
      default: begin
        phase = PH_IDLE;
        if (b == IAC_BYTE) phase = PH_IAC;
        else if (!b[7]) push_beat(KIND_DATA, b, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t tsp_checker: %s differs, expected 0x%0h actual 0x%0h",
               $time, name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      expected_beats.delete();
      phase    = PH_IDLE;
      cmd_hold = 8'h00;
      opt_hold = 8'h00;
      dir_hold = 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_byte);
      if (out_valid && out_ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          $display("%0t tsp_checker: unexpected beat, expected none actual kind %0d value 0x%0h",
                   $time, out_kind, out_value);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("value_byte", 32'(want.value), 32'(out_value));
          check_field("option_code", 32'(want.option), 32'(out_option));
          check_field("direction_flag", 32'(want.dir), 32'(out_dir));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    pending_count <= expected_beats.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte stimulus, receiver stalls, watchdog and verdict.
module tb;
  import tsp_pkg::*;

  localparam int RANDOM_BYTES   = 550;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;

  tsp_in_if  in_ch ();
  tsp_out_if out_ch ();

  int fail_count;
  int pending_count;
  int beats_checked;
  int bytes_sent;
  int subneg_count;
  int burst_left;
  int idle_cycles;
  int stall_left;
  int ready_mode;
  int mode_left;

  telnet_stream_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tsp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.rx_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_value     (out_ch.value_byte),
    .out_option    (out_ch.option_code),
    .out_dir       (out_ch.direction_flag),
    .out_last      (out_ch.last),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Receiver: switches between always-ready, sparse, periodic and long-stall modes.
  initial begin
    out_ch.ready = 1'b0;
    ready_mode   = 0;
    mode_left    = 0;
    stall_left   = 0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (mode_left % 8 > 2);
      3: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left == 0) stall_left = $urandom_range(5, 30);
        stall_left--;
        out_ch.ready <= (stall_left == 0);
      end
    endcase
  end

  // Watchdog on cycles in which neither channel moves a beat.
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_count);
        $display("telnet_stream_parser: mismatch");
        $finish;
      end
    end
  end

  // Sender works in bursts; a gap between bursts drops valid.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 12);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_subneg(input int pay_len, input bit with_end);
    int r;
    subneg_count++;
    send_byte(IAC_BYTE);
    send_byte(SB_BYTE);
    send_byte(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 9);
    send_byte(8'((r < 3) ? $urandom_range(0, 255) : $urandom_range(0, 1)));
    for (int i = 0; i < pay_len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_byte(IAC_BYTE);
        send_byte(8'($urandom_range(0, 255)));
      end else if (r == 1) begin
        send_byte(IAC_BYTE);
        send_byte(IAC_BYTE);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    if (with_end) begin
      send_byte(IAC_BYTE);
      send_byte(SE_BYTE);
    end
  endtask

  task automatic run_random();
    int sel;
    int n;
    logic [7:0] cmd;
    while (bytes_sent < RANDOM_BYTES + 27) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(0, 127)));
      end else if (sel < 40) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 60) begin
        cmd = 8'($urandom_range(0, 255));
        if (cmd == SB_BYTE) cmd = IAC_BYTE;
        send_byte(IAC_BYTE);
        send_byte(cmd);
        send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 92) begin
        send_subneg(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                : $urandom_range(0, 8),
                    $urandom_range(0, 9) != 0);
      end else begin
        // stray end marker outside a subnegotiation
        send_byte(IAC_BYTE);
        send_byte(SE_BYTE);
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    bytes_sent    = 0;
    subneg_count  = 0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data extremes, a dropped high byte, a command, IAC IAC as a command,
    // a subnegotiation with escaped IAC and IAC-then-byte, an empty one
    directed = '{8'h00, 8'h7F, 8'h80,
                 IAC_BYTE, 8'hFB, 8'h01,
                 IAC_BYTE, IAC_BYTE, 8'hFF,
                 IAC_BYTE, SB_BYTE, 8'hFF, 8'h01, 8'h41, IAC_BYTE, IAC_BYTE,
                 8'h00, IAC_BYTE, 8'h7E, IAC_BYTE, SE_BYTE,
                 IAC_BYTE, SB_BYTE, 8'h00, 8'h00, IAC_BYTE, SE_BYTE};
    subneg_count = 2;
    foreach (directed[i]) send_byte(directed[i]);

    run_random();
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input bytes with %0d subnegotiations; %0d result beats checked.",
             bytes_sent, subneg_count, beats_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("telnet_stream_parser: match");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending_count);
      $display("telnet_stream_parser: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tsp_pkg.sv
rtl/tsp_if.sv
rtl/tsp_front.sv
rtl/tsp_queue.sv
rtl/tsp_back.sv
rtl/telnet_stream_parser.sv
tb/sv/tsp_checker.sv
tb/sv/tb.sv
